### rtl/sfpg_pkg.sv
`timescale 1ns / 1ps

package sfpg_pkg;

    localparam int SPECTRUM_BINS = 4096;
    localparam int BIN_W         = 12;
    localparam int FINE_W        = 15;
    localparam int COARSE_LSB    = 15;
    localparam int WORD_W        = 32;
    localparam int POWER_W       = 31;
    localparam int TALLY_W       = 16;
    localparam int CLEAN_W       = 32;

    localparam int IN_TDATA_W    = 2 * WORD_W;
    localparam int OUT_FIELD_W   = BIN_W + POWER_W + TALLY_W + CLEAN_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [BIN_W-1:0]   LAST_BIN  = BIN_W'(SPECTRUM_BINS - 1);
    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    typedef struct packed {
        logic [CLEAN_W-1:0] clean_packet_total;
        logic [TALLY_W-1:0] packet_jump_count;
        logic [POWER_W-1:0] peak_power;
        logic [BIN_W-1:0]   peak_channel;
    } t_result;

endpackage

### rtl/spectrum_frame_peak_and_gap_check_unit.sv
`timescale 1ns / 1ps

// channel  | direction | tdata (low bit up)                            | tuser      | tlast
// s_axis   | in        | status_word[31:0], power_word[63:32]          | -          | packet_last
// m_axis   | out       | peak_channel, peak_power, packet_jump_count,  | frame_done | packet_done
//          |           | clean_packet_total, zero fill to 96 bits      |            |
//
// one record per cycle sustained while m_axis_tready is high
// input register feeds one compare/count stage into the result register
// i_rst_n is synchronous, active low, and clears all frame and packet state
// a stalled m_axis holds the result; with both registers full s_axis_tready equals m_axis_tready
module spectrum_frame_peak_and_gap_check_unit
    import sfpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // status_word, power_word
    input  logic                   s_axis_tlast,   // packet_last

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // peak_channel, peak_power,
                                                   // packet_jump_count, clean_packet_total
    output logic                   m_axis_tuser,   // frame_done
    output logic                   m_axis_tlast    // packet_done
);

    logic                  r_in_valid;
    logic [WORD_W-1:0]     r_in_status;
    logic [WORD_W-1:0]     r_in_power;
    logic                  r_in_last;

    logic [BIN_W-1:0]      r_cap;
    logic [POWER_W-1:0]    r_lower_pwr;
    logic [BIN_W-1:0]      r_lower_bin;
    logic [POWER_W-1:0]    r_upper_pwr;
    logic [BIN_W-1:0]      r_upper_bin;
    logic [BIN_W-1:0]      r_prev_coarse;
    logic [TALLY_W-1:0]    r_tally;
    logic [CLEAN_W-1:0]    r_clean;

    logic                  r_out_valid;
    t_result               r_out;
    logic                  r_out_frame;
    logic                  r_out_packet;

    logic                  s_fire;
    logic                  adv;

    logic [FINE_W-1:0]     fine;
    logic [BIN_W-1:0]      coarse;
    logic [POWER_W-1:0]    power;
    logic                  hit;
    logic                  frame_end;
    logic [POWER_W-1:0]    n_lower_pwr;
    logic [BIN_W-1:0]      n_lower_bin;
    logic [POWER_W-1:0]    n_upper_pwr;
    logic [BIN_W-1:0]      n_upper_bin;
    logic [BIN_W-1:0]      step;
    logic                  jump;
    logic [TALLY_W-1:0]    n_tally;
    logic [CLEAN_W-1:0]    n_clean;
    t_result               n_out;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_comb begin
        fine   = r_in_status[FINE_W-1:0];
        coarse = r_in_status[COARSE_LSB +: BIN_W];
        if (r_in_power[WORD_W-1] || (r_in_power == '0)) begin
            power = POWER_W'(1);
        end else begin
            power = r_in_power[POWER_W-1:0];
        end

        hit       = (fine == '0) && (coarse == r_cap);
        frame_end = hit && (r_cap == LAST_BIN);

        n_lower_pwr = r_lower_pwr;
        n_lower_bin = r_lower_bin;
        n_upper_pwr = r_upper_pwr;
        n_upper_bin = r_upper_bin;
        if (hit && !coarse[BIN_W-1] && (power > r_lower_pwr)) begin
            n_lower_pwr = power;
            n_lower_bin = coarse;
        end
        if (hit && coarse[BIN_W-1] && (power > r_upper_pwr)) begin
            n_upper_pwr = power;
            n_upper_bin = coarse;
        end

        n_out = '0;
        if (frame_end) begin
            // half swap is a flip of the top bin bit
            if (n_lower_pwr > n_upper_pwr) begin
                n_out.peak_channel = {~n_lower_bin[BIN_W-1], n_lower_bin[BIN_W-2:0]};
                n_out.peak_power   = n_lower_pwr;
            end else begin
                n_out.peak_channel = {~n_upper_bin[BIN_W-1], n_upper_bin[BIN_W-2:0]};
                n_out.peak_power   = n_upper_pwr;
            end
        end

        step = coarse - r_prev_coarse;
        jump = (step > BIN_W'(1));
        if (jump && (r_tally != TALLY_MAX)) begin
            n_tally = r_tally + TALLY_W'(1);
        end else begin
            n_tally = r_tally;
        end
        if (n_tally == '0) begin
            n_clean = r_clean + CLEAN_W'(1);
        end else begin
            n_clean = r_clean;
        end
        if (r_in_last) begin
            n_out.packet_jump_count  = n_tally;
            n_out.clean_packet_total = n_clean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_status <= s_axis_tdata[WORD_W-1:0];
            r_in_power  <= s_axis_tdata[WORD_W +: WORD_W];
            r_in_last   <= s_axis_tlast;
        end
        if (adv) begin
            r_out        <= n_out;
            r_out_frame  <= frame_end;
            r_out_packet <= r_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cap         <= '0;
            r_lower_pwr   <= '0;
            r_lower_bin   <= '0;
            r_upper_pwr   <= '0;
            r_upper_bin   <= '0;
            r_prev_coarse <= '0;
            r_tally       <= '0;
            r_clean       <= '0;
        end else begin
            if (s_fire) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                if (frame_end) begin
                    r_cap       <= '0;
                    r_lower_pwr <= '0;
                    r_lower_bin <= '0;
                    r_upper_pwr <= '0;
                    r_upper_bin <= '0;
                end else begin
                    if (hit) begin
                        r_cap <= r_cap + BIN_W'(1);
                    end
                    r_lower_pwr <= n_lower_pwr;
                    r_lower_bin <= n_lower_bin;
                    r_upper_pwr <= n_upper_pwr;
                    r_upper_bin <= n_upper_bin;
                end
                r_prev_coarse <= coarse;
                if (r_in_last) begin
                    r_tally <= '0;
                    r_clean <= n_clean;
                end else begin
                    r_tally <= n_tally;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);
    assign m_axis_tuser  = r_out_frame;
    assign m_axis_tlast  = r_out_packet;

`ifndef ASSERT_OFF
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap == '0) |-> (r_lower_pwr == '0) && (r_upper_pwr == '0))
        else $error("frame maxima not cleared at counter zero");

    a_upper_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upper_pwr != '0) |-> r_cap[BIN_W-1] && r_upper_bin[BIN_W-1])
        else $error("upper half peak held before upper half captured");

    a_peak_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_frame) |-> (r_out.peak_power != '0))
        else $error("completed frame reported zero peak");

    a_packet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_packet) |->
            (r_out.packet_jump_count == '0) && (r_out.clean_packet_total == '0))
        else $error("packet fields set without packet end");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_frame) |->
            (r_out.peak_power == '0) && (r_out.peak_channel == '0))
        else $error("peak fields set without frame end");
`endif

endmodule

### sim/spectrum_peak_gap_scoreboard.sv
`timescale 1ns / 1ps

module spectrum_peak_gap_scoreboard
    import sfpg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_rec_valid,
    input  logic                   i_rec_ready,
    input  logic [IN_TDATA_W-1:0]  i_rec_data,     // status_word, power_word
    input  logic                   i_rec_last,     // packet_last

    input  logic                   i_rep_valid,
    input  logic                   i_rep_ready,
    input  logic [OUT_TDATA_W-1:0] i_rep_data,     // peak_channel, peak_power,
                                                   // packet_jump_count, clean_packet_total
    input  logic                   i_rep_frame,    // frame_done
    input  logic                   i_rep_packet,   // packet_done

    output int                     o_errors,
    output int                     o_backlog
);

    localparam logic [BIN_W-1:0] HALF_BIN = BIN_W'(SPECTRUM_BINS / 2);

    typedef struct packed {
        logic    frame_done;
        logic    packet_done;
        t_result fields;
    } t_report;

    t_report pending_reports[$];
    int      error_count = 0;
    int      report_backlog = 0;

    logic [BIN_W-1:0]   capture_bin;
    logic [WORD_W-1:0]  lower_peak;
    logic [BIN_W-1:0]   lower_bin;
    logic [WORD_W-1:0]  upper_peak;
    logic [BIN_W-1:0]   upper_bin;
    logic [BIN_W-1:0]   prev_coarse;
    logic [TALLY_W-1:0] jump_tally;
    logic [CLEAN_W-1:0] clean_total;

    assign o_errors  = error_count;
    assign o_backlog = report_backlog;

    function automatic void clear_frame();
        capture_bin = '0;
        lower_peak  = '0;
        lower_bin   = '0;
        upper_peak  = '0;
        upper_bin   = '0;
    endfunction

    function automatic t_report predict_report(input logic [WORD_W-1:0] status,
                                               input logic [WORD_W-1:0] power_raw,
                                               input logic last);
        logic [BIN_W-1:0]  coarse;
        logic [FINE_W-1:0] fine;
        logic [WORD_W-1:0] power;
        logic [BIN_W-1:0]  step;
        t_report           rep;
        coarse = status[COARSE_LSB +: BIN_W];
        fine   = status[FINE_W-1:0];
        power  = ($signed(power_raw) < 1) ? 32'd1 : power_raw;
        rep    = '0;

        if (fine == '0 && coarse == capture_bin) begin
            if (coarse < HALF_BIN) begin
                if (power > lower_peak) begin
                    lower_peak = power;
                    lower_bin  = coarse;
                end
            end else if (power > upper_peak) begin
                upper_peak = power;
                upper_bin  = coarse;
            end
            if (capture_bin == LAST_BIN) begin
                // upper half comes first in swapped order, so it keeps ties
                rep.frame_done = 1'b1;
                if (lower_peak > upper_peak) begin
                    rep.fields.peak_channel = lower_bin + HALF_BIN;
                    rep.fields.peak_power   = lower_peak[POWER_W-1:0];
                end else begin
                    rep.fields.peak_channel = upper_bin - HALF_BIN;
                    rep.fields.peak_power   = upper_peak[POWER_W-1:0];
                end
                clear_frame();
            end else begin
                capture_bin = capture_bin + BIN_W'(1);
            end
        end

        // same bin or next bin modulo 4096 is in sequence
        step = coarse - prev_coarse;
        if (step > BIN_W'(1) && jump_tally != TALLY_MAX)
            jump_tally = jump_tally + TALLY_W'(1);
        prev_coarse = coarse;

        if (last) begin
            if (jump_tally == '0)
                clean_total = clean_total + CLEAN_W'(1);
            rep.packet_done              = 1'b1;
            rep.fields.packet_jump_count = jump_tally;
            rep.fields.clean_packet_total = clean_total;
            jump_tally = '0;
        end
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_report want;
        if (!i_rst_n) begin
            clear_frame();
            prev_coarse = '0;
            jump_tally  = '0;
            clean_total = '0;
            pending_reports.delete();
        end else begin
            if (i_rep_valid && i_rep_ready) begin
                got = t_result'(i_rep_data[OUT_FIELD_W-1:0]);
                if (pending_reports.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected transfer, expected none, actual %h %b %b",
                             $time, i_rep_data, i_rep_frame, i_rep_packet);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("frame_done", 32'(want.frame_done), 32'(i_rep_frame));
                    check_field("packet_done", 32'(want.packet_done), 32'(i_rep_packet));
                    check_field("peak_channel", 32'(want.fields.peak_channel),
                                32'(got.peak_channel));
                    check_field("peak_power", 32'(want.fields.peak_power),
                                32'(got.peak_power));
                    check_field("packet_jump_count", 32'(want.fields.packet_jump_count),
                                32'(got.packet_jump_count));
                    check_field("clean_packet_total", want.fields.clean_packet_total,
                                got.clean_packet_total);
                end
            end
            if (i_rec_valid && i_rec_ready)
                pending_reports.push_back(predict_report(i_rec_data[WORD_W-1:0],
                                                         i_rec_data[2*WORD_W-1:WORD_W],
                                                         i_rec_last));
        end
        report_backlog = pending_reports.size();
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfpg_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_COUNT = 1630;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // status_word, power_word
    logic                   s_axis_tlast;   // packet_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // peak_channel, peak_power,
                                            // packet_jump_count, clean_packet_total
    logic                   m_axis_tuser;   // frame_done
    logic                   m_axis_tlast;   // packet_done

    int               error_total;
    int               backlog;
    int               cycle_count;
    int               tx_quiet = 0;
    int               rx_quiet = 0;
    int               out_count = 0;
    int               records_sent = 0;
    int               packets_sent = 0;
    logic [BIN_W-1:0] next_bin = '0;
    logic [BIN_W-1:0] sent_coarse = '0;

    spectrum_frame_peak_and_gap_check_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    spectrum_peak_gap_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (s_axis_tvalid),
        .i_rec_ready  (s_axis_tready),
        .i_rec_data   (s_axis_tdata),
        .i_rec_last   (s_axis_tlast),
        .i_rep_valid  (m_axis_tvalid),
        .i_rep_ready  (m_axis_tready),
        .i_rep_data   (m_axis_tdata),
        .i_rep_frame  (m_axis_tuser),
        .i_rep_packet (m_axis_tlast),
        .o_errors     (error_total),
        .o_backlog    (backlog)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // idle cycles before the next transfer, with runs of back-to-back transfers
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [WORD_W-1:0] make_status(input logic [4:0] top,
                                                      input logic [BIN_W-1:0] coarse,
                                                      input logic [FINE_W-1:0] fine);
        return {top, coarse, fine};
    endfunction

    task automatic push_record(input logic [WORD_W-1:0] status,
                               input logic [WORD_W-1:0] power_raw,
                               input logic last);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {power_raw, status};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        records_sent++;
        if (last)
            packets_sent++;
        sent_coarse = status[COARSE_LSB +: BIN_W];
        if (status[FINE_W-1:0] == '0 && sent_coarse == next_bin)
            next_bin = next_bin + BIN_W'(1);
    endtask

    // result side, with one long hold-off so the input backs up
    initial begin
        int idle;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (out_count == HOLD_AT)
                idle = HOLD_CYCLES;
            else
                idle = draw_gap(rx_quiet);
            if (idle > 0) begin
                m_axis_tready <= 1'b0;
                repeat (idle) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            out_count++;
            @(negedge i_clk);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, backlog);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int                r;
        int                kind;
        int                random_count;
        int                i;
        int                wait_cycles;
        logic [BIN_W-1:0]  coarse;
        logic [FINE_W-1:0] fine;
        logic [WORD_W-1:0] pw;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: clamps, fine bin set, out of order, wrap, backward step, all ones
        push_record(make_status(5'h00, 12'd0, 15'd0), 32'h0000_0000, 1'b0);
        push_record(make_status(5'h00, 12'd1, 15'd0), 32'h8000_0000, 1'b0);
        push_record(make_status(5'h1f, 12'd2, 15'h7fff), 32'h7fff_ffff, 1'b1);
        push_record(make_status(5'h00, 12'd2, 15'd0), 32'h7fff_ffff, 1'b0);
        push_record(make_status(5'h15, 12'd4095, 15'd0), 32'h0000_0001, 1'b1);
        push_record(make_status(5'h0a, 12'd0, 15'd0), 32'hffff_ffff, 1'b1);
        push_record(make_status(5'h00, 12'd3, 15'd0), 32'hffff_ffff, 1'b0);
        push_record(make_status(5'h00, 12'd3, 15'd1), 32'h0000_0005, 1'b0);
        push_record(make_status(5'h00, 12'd2, 15'd0), 32'h0000_0002, 1'b1);
        push_record(make_status(5'h00, 12'd4, 15'd0), 32'h7fff_ffff, 1'b0);
        push_record(make_status(5'h00, 12'd5, 15'd0), 32'h7fff_ffff, 1'b1);
        push_record(32'hffff_ffff, 32'h7fff_ffff, 1'b1);
        push_record(make_status(5'h00, 12'd2048, 15'h4000), 32'h8000_0001, 1'b0);
        push_record(make_status(5'h00, 12'd2049, 15'd0), 32'h0000_0000, 1'b1);

        // mostly in-order captures; the power profile changes over the run
        random_count = 0;
        while (random_count < RANDOM_COUNT) begin
            kind   = (random_count / 550) % 3;
            r      = $urandom_range(0, 99);
            coarse = next_bin;
            fine   = '0;
            if (r >= 82 && r < 88)
                coarse = sent_coarse;
            else if (r >= 88 && r < 94)
                fine = FINE_W'($urandom_range(1, 32767));
            else if (r >= 94)
                coarse = BIN_W'($urandom_range(0, 4095));
            case (kind)
                0: pw = $urandom;
                1: pw = $urandom_range(0, 8) - 5;
                default: begin
                    if (coarse < 12'd2048)
                        pw = $urandom_range(1000, 32'h7fff_ffff);
                    else
                        pw = $urandom_range(0, 999) - 500;
                end
            endcase
            push_record(make_status(5'($urandom_range(0, 31)), coarse, fine), pw,
                        $urandom_range(0, 11) == 0);
            random_count++;
        end

        for (i = 0; i < 6; i++)
            push_record(make_status(5'($urandom_range(0, 31)), 12'd2,
                                    FINE_W'($urandom_range(0, 1))),
                        $urandom, i % 3 == 2);

        s_axis_tvalid <= 1'b0;
        while (backlog != 0) @(negedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 20) begin
            @(negedge i_clk);
            wait_cycles++;
        end

        $display("%0d records in %0d packets: power clamps, fine-bin and out-of-order records,",
                 records_sent, packets_sent);
        $display("sequence jumps and wraps, random idles on both sides and one long hold-off");
        if (error_total == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
